@@ rtl/pulse_period_high_capture_core_defines.svh @@
// ----------------------------------------------------------------------------
// Pulse period / high-time capture: assertion macros
// Shared assertion helpers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_HIGH_CAPTURE_CORE_DEFINES_SVH
`define PULSE_PERIOD_HIGH_CAPTURE_CORE_DEFINES_SVH

// same-cycle implication
`define PPHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pphc_pkg.sv @@
// ----------------------------------------------------------------------------
// pphc_pkg
// Types and constants shared by the pulse capture core and its update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pphc_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;
    localparam int TS_W     = 32;
    localparam int MIN_W    = 16;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [MIN_W-1:0] MIN_PERIOD_RESET = 16'd10;

    // register index as seen on paddr[2]
    localparam logic REG_MIN_PERIOD = 1'b0;

    // per-channel state entry
    typedef struct packed {
        logic [TS_W-1:0] last_rise;
        logic [TS_W-1:0] last_edge;
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] high;
        logic            valid;
    } t_entry;

    // one reported measurement
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [TS_W-1:0] period;
        logic [TS_W-1:0] high;
        logic            period_valid;
        logic            rolled_over;
    } t_result;

    // captured edge
    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic [TS_W-1:0] timestamp;
        logic            rising;
    } t_edge_evt;

endpackage

`default_nettype wire

@@ rtl/pphc_update.sv @@
// ----------------------------------------------------------------------------
// pphc_update
// Read-modify-write step for one edge: new channel entry plus its result.
// ----------------------------------------------------------------------------
`default_nettype none

module pphc_update (
    input  wire pphc_pkg::t_edge_evt             i_evt,
    input  wire pphc_pkg::t_entry                i_entry,
    input  wire logic [pphc_pkg::MIN_W-1:0]      i_min_period,
    output pphc_pkg::t_entry                     o_entry,
    output logic                                 o_write,
    output pphc_pkg::t_result                    o_result
);

    logic                      in_range;
    logic                      rollover;
    logic                      has_rise;
    logic [pphc_pkg::TS_W-1:0] delta;

    assign in_range = (int'(i_evt.channel) < pphc_pkg::CHANNELS);
    assign rollover = (i_entry.last_edge != '0) && (i_evt.timestamp < i_entry.last_edge);
    assign has_rise = (i_entry.last_rise != '0);
    assign delta    = i_evt.timestamp - i_entry.last_rise;

    always_comb begin
        o_entry = i_entry;
        if (rollover) begin
            o_entry = '0;
        end else if (i_evt.rising) begin
            if (has_rise) begin
                o_entry.period = delta;
                o_entry.valid  = (delta > {{(pphc_pkg::TS_W-pphc_pkg::MIN_W){1'b0}},
                                           i_min_period});
            end else begin
                o_entry.valid = 1'b0;
            end
            o_entry.last_rise = i_evt.timestamp;
        end else begin
            if (has_rise && (i_evt.timestamp >= i_entry.last_rise)) begin
                o_entry.high = delta;
                if (i_entry.valid && (delta > i_entry.period)) begin
                    o_entry.valid = 1'b0;
                end
            end else begin
                o_entry.high  = '0;
                o_entry.valid = 1'b0;
            end
        end
        o_entry.last_edge = i_evt.timestamp;
    end

    assign o_write = in_range;

    always_comb begin
        o_result         = '0;
        o_result.channel = i_evt.channel;
        if (in_range) begin
            o_result.period       = o_entry.period;
            o_result.high         = o_entry.high;
            o_result.period_valid = o_entry.valid;
            o_result.rolled_over  = rollover;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pulse_period_high_capture_core.sv @@
// ----------------------------------------------------------------------------
// pulse_period_high_capture_core
// Per-channel pulse period and high-time measurement from captured edges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one captured edge per
//   transaction - channel, free-running timestamp, polarity.
//   Output channel (o_out_valid / i_out_ready): one result per edge with
//   the channel's period, high time, valid flag and a rollover marker.
//   APB port: register 0 (byte address 0) is min_period_ticks, 16 bits.
//   Write it only while no edge is in flight.
// Timing:
//   An accepted edge reads the state memory into the update stage register
//   as it is accepted; the update logic then writes the new entry and the
//   output register, from which the result is shown. Throughput is one
//   edge per cycle while the output is not held, set by the single
//   read-modify-write pass over the state memory; back-to-back edges on
//   the same channel are served by forwarding the last written entry.
// Reset:
//   Per-entry valid flags clear at once, so every channel reads as all
//   zero after reset; no clearing pass. min_period_ticks returns to 10.
// Stall:
//   When the output is held with an edge in the update stage, the stage holds and input ready drops in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_period_high_capture_core_defines.svh"

module pulse_period_high_capture_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // edge input
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [pphc_pkg::CH_W-1:0]      i_channel,
    input  wire logic [pphc_pkg::TS_W-1:0]      i_timestamp,
    input  wire logic                           i_edge_rising,
    // measurement output
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [pphc_pkg::CH_W-1:0]           o_out_channel,
    output logic [pphc_pkg::TS_W-1:0]           o_period_ticks,
    output logic [pphc_pkg::TS_W-1:0]           o_high_ticks,
    output logic                                o_period_valid,
    output logic                                o_rolled_over,
    // APB configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pphc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pphc_pkg::DATA_W-1:0]    pwdata,
    output logic [pphc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [pphc_pkg::MIN_W-1:0] r_min_period;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pphc_pkg::REG_MIN_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= pphc_pkg::MIN_PERIOD_RESET;
        end else if (cfg_wr) begin
            r_min_period <= pwdata[pphc_pkg::MIN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == pphc_pkg::REG_MIN_PERIOD) begin
            prdata = {{(pphc_pkg::DATA_W-pphc_pkg::MIN_W){1'b0}}, r_min_period};
        end
    end

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // ------------------------------------------------------------------
    logic in_accept;
    logic s1_adv;
    logic r_s1_valid;
    logic r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // State memory: one entry per channel, sync read, one write port
    // ------------------------------------------------------------------
    pphc_pkg::t_entry             r_mem [pphc_pkg::CHANNELS];
    logic [pphc_pkg::CHANNELS-1:0] r_ent_ok;   // entry written since reset
    pphc_pkg::t_entry             r_rdata;
    logic                         r_rd_ok;
    pphc_pkg::t_edge_evt          r_s1_evt;

    // last written entry, to cover a read that raced the write
    logic                         r_fwd_ok;
    logic [pphc_pkg::CH_W-1:0]    r_fwd_ch;
    pphc_pkg::t_entry             r_fwd_entry;

    pphc_pkg::t_entry             cur_entry;
    pphc_pkg::t_entry             new_entry;
    logic                         upd_write;
    logic                         mem_we;
    pphc_pkg::t_result            upd_result;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rdata           <= r_mem[i_channel];
            r_rd_ok           <= r_ent_ok[i_channel];
            r_s1_evt.channel  <= i_channel;
            r_s1_evt.timestamp <= i_timestamp;
            r_s1_evt.rising   <= i_edge_rising;
        end
        if (mem_we) begin
            r_mem[r_s1_evt.channel] <= new_entry;
            r_fwd_ch                <= r_s1_evt.channel;
            r_fwd_entry             <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_ok   <= '0;
            r_fwd_ok   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_ent_ok[r_s1_evt.channel] <= 1'b1;
                r_fwd_ok                   <= 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // newest copy of the entry: forwarded write, memory, or reset value
    always_comb begin
        if (r_fwd_ok && (r_fwd_ch == r_s1_evt.channel)) begin
            cur_entry = r_fwd_entry;
        end else if (r_rd_ok) begin
            cur_entry = r_rdata;
        end else begin
            cur_entry = '0;
        end
    end

    pphc_update u_update (
        .i_evt        (r_s1_evt),
        .i_entry      (cur_entry),
        .i_min_period (r_min_period),
        .o_entry      (new_entry),
        .o_write      (upd_write),
        .o_result     (upd_result)
    );

    assign mem_we = s1_adv && upd_write;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    pphc_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= upd_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_channel  = r_out.channel;
    assign o_period_ticks = r_out.period;
    assign o_high_ticks   = r_out.high;
    assign o_period_valid = r_out.period_valid;
    assign o_rolled_over  = r_out.rolled_over;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PPHC_ASSERT_NOW(a_rollover_clears, o_out_valid && o_rolled_over,
        (o_period_ticks == '0) && (o_high_ticks == '0) && !o_period_valid,
        "rollover result not cleared")
    `PPHC_ASSERT_NEXT(a_accept_fills_s1, in_accept, r_s1_valid,
        "accepted edge lost before update")
    `PPHC_ASSERT_NEXT(a_s1_holds, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_evt),
        "update stage changed while stalled")

endmodule

`default_nettype wire
